// ----- rtl/core/mccl_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI controller learn mapper package
// Shared widths, codes and the word types passed between front, queue and back.
// ----------------------------------------------------------------------------
package mccl_pkg;

  localparam int unsigned FuncW     = 3;
  localparam int unsigned StatusW   = 8;
  localparam int unsigned DataW     = 7;
  localparam int unsigned CcW       = 7;
  localparam int unsigned ParamW    = 12;
  localparam int unsigned MapW      = 13;
  localparam int unsigned ChanW     = 5;
  localparam int unsigned CountW    = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam int unsigned CcCount   = 128;
  localparam int unsigned ScanCntW  = $clog2(CcCount + 1);

  // The command queue depth must be a power of two.
  localparam int unsigned QDepth    = 2;

  localparam logic [FuncW-1:0] FuncMsg     = 3'd0;
  localparam logic [FuncW-1:0] FuncConnect = 3'd1;
  localparam logic [FuncW-1:0] FuncRemove  = 3'd2;
  localparam logic [FuncW-1:0] FuncArm     = 3'd3;
  localparam logic [FuncW-1:0] FuncLookup  = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgMidiChannel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCcIntercept = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgParamCount  = 2'd2;

  localparam logic [3:0] NibbleCc     = 4'hB;
  localparam logic [3:0] NibbleSystem = 4'hF;
  localparam logic [ChanW-1:0] ChanLast = 5'd16;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MSG,
    OP_CC,
    OP_CONNECT,
    OP_REMOVE,
    OP_ARM,
    OP_DISARM,
    OP_LOOKUP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             fwd;
    logic [CcW-1:0]   cc;
    logic [ParamW-1:0] param;
    logic [DataW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ChanW-1:0]  midi_channel;
    logic              cc_intercept;
    logic [CountW-1:0] param_count;
  } cfg_t;

endpackage

// ----- rtl/core/mccl_in_if.sv -----
// ----------------------------------------------------------------------------
// MIDI controller learn mapper input channel
// Valid/ready channel carrying one message or mapping command word.
// ----------------------------------------------------------------------------
interface mccl_in_if;

  logic                            valid;
  logic                            ready;
  logic [mccl_pkg::FuncW-1:0]      func;
  logic [mccl_pkg::StatusW-1:0]    status_byte;
  logic [mccl_pkg::DataW-1:0]      data_first;
  logic [mccl_pkg::DataW-1:0]      data_second;
  logic [mccl_pkg::CcW-1:0]        cc_index;
  logic [mccl_pkg::ParamW-1:0]     param_index;

  modport source (
    output valid, func, status_byte, data_first, data_second, cc_index, param_index,
    input  ready
  );

  modport sink (
    input  valid, func, status_byte, data_first, data_second, cc_index, param_index,
    output ready
  );

endinterface

// ----- rtl/core/mccl_out_if.sv -----
// ----------------------------------------------------------------------------
// MIDI controller learn mapper output channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface mccl_out_if;

  logic                             valid;
  logic                             ready;
  logic                             forward;
  logic                             param_write;
  logic [mccl_pkg::ParamW-1:0]      write_index;
  logic [mccl_pkg::DataW-1:0]       write_value;
  logic signed [mccl_pkg::MapW-1:0] mapped_param;

  modport source (
    output valid, forward, param_write, write_index, write_value, mapped_param,
    input  ready
  );

  modport sink (
    input  valid, forward, param_write, write_index, write_value, mapped_param,
    output ready
  );

endinterface

// ----- rtl/core/mccl_front.sv -----
// ----------------------------------------------------------------------------
// MIDI controller learn mapper front end
// Accepts input words, applies the channel filter and decodes each word into
// a back-end operation.
// ----------------------------------------------------------------------------
module mccl_front (
  mccl_in_if.sink          in_i,
  input  mccl_pkg::cfg_t   cfg_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output mccl_pkg::cmd_t   push_data_o
);

  logic [mccl_pkg::ChanW-1:0] filt;
  logic [mccl_pkg::ChanW-1:0] chan;
  logic                       pass;
  logic                       is_cc;
  logic                       in_range;

  always_comb begin
    if (cfg_i.midi_channel != '0 && cfg_i.midi_channel <= mccl_pkg::ChanLast) begin
      filt = cfg_i.midi_channel;
    end else begin
      filt = '0;
    end
    if (in_i.status_byte[7:4] != mccl_pkg::NibbleSystem) begin
      chan = {1'b0, in_i.status_byte[3:0]} + 5'd1;
    end else begin
      chan = '0;
    end
  end

  assign pass     = (filt == '0) || (chan == filt);
  assign is_cc    = in_i.status_byte[7:4] == mccl_pkg::NibbleCc;
  assign in_range = {1'b0, in_i.param_index} < cfg_i.param_count;

  always_comb begin
    push_data_o       = '0;
    push_data_o.param = in_i.param_index;
    push_data_o.cc    = in_i.cc_index;
    push_data_o.value = in_i.data_second;
    case (in_i.func)
      mccl_pkg::FuncMsg: begin
        if (!pass) begin
          push_data_o.op = mccl_pkg::OP_NOP;
        end else if (is_cc) begin
          push_data_o.op  = mccl_pkg::OP_CC;
          push_data_o.cc  = in_i.data_first;
          push_data_o.fwd = !cfg_i.cc_intercept;
        end else begin
          push_data_o.op  = mccl_pkg::OP_MSG;
          push_data_o.fwd = 1'b1;
        end
      end
      mccl_pkg::FuncConnect: begin
        push_data_o.op = in_range ? mccl_pkg::OP_CONNECT : mccl_pkg::OP_NOP;
      end
      mccl_pkg::FuncRemove: begin
        push_data_o.op = mccl_pkg::OP_REMOVE;
      end
      mccl_pkg::FuncArm: begin
        push_data_o.op = in_range ? mccl_pkg::OP_ARM : mccl_pkg::OP_DISARM;
      end
      mccl_pkg::FuncLookup: begin
        push_data_o.op = mccl_pkg::OP_LOOKUP;
      end
      default: begin
        push_data_o.op = mccl_pkg::OP_NOP;
      end
    endcase
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

endmodule

// ----- rtl/core/mccl_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// MIDI controller learn mapper command queue
// Short queue of decoded words between the front end and the back end.
// ----------------------------------------------------------------------------
module mccl_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  mccl_pkg::cmd_t   push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output mccl_pkg::cmd_t   pop_data_o
);

  localparam int unsigned PtrW = $clog2(mccl_pkg::QDepth);
  localparam int unsigned CntW = $clog2(mccl_pkg::QDepth + 1);

  mccl_pkg::cmd_t  entries_q [mccl_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = cnt_q != CntW'(mccl_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/mccl_back.sv -----
// ----------------------------------------------------------------------------
// MIDI controller learn mapper back end
// Holds the controller map and learn slot, executes decoded words and drives
// the registered result word.
// ----------------------------------------------------------------------------
module mccl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mccl_pkg::cfg_t   cfg_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  mccl_pkg::cmd_t   pop_data_i,
  mccl_out_if.source       out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESOLVE
  } state_e;

  localparam int unsigned SW = mccl_pkg::ScanCntW;
  localparam int unsigned CW = mccl_pkg::CcW;
  localparam int unsigned PW = mccl_pkg::ParamW;

  state_e                      state_q;
  mccl_pkg::cmd_t              cmd_q;
  logic [SW-1:0]               cnt_q;
  logic                        rd_vld_q;
  logic [CW-1:0]               rd_addr_q;
  logic [PW-1:0]               rd_data_q;
  logic [mccl_pkg::CcCount-1:0] map_vld_q;
  logic                        learn_vld_q;
  logic [PW-1:0]               learn_q;
  logic                        use_learn_q;
  logic [PW-1:0]               mem_q [mccl_pkg::CcCount];

  logic                        out_vld_q;
  logic                        out_fwd_q;
  logic                        out_wr_q;
  logic [PW-1:0]               out_idx_q;
  logic [mccl_pkg::DataW-1:0]  out_val_q;
  logic signed [mccl_pkg::MapW-1:0] out_map_q;

  logic          take;
  logic          found;
  logic          scan_done;
  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [PW-1:0] wr_data;
  logic          out_free;
  logic [PW-1:0] cc_param;
  logic          res_fwd;
  logic          res_wr;
  logic [PW-1:0] res_idx;
  logic [mccl_pkg::DataW-1:0] res_val;
  logic signed [mccl_pkg::MapW-1:0] res_map;

  assign pop_ready_o = state_q == S_IDLE;
  assign take        = pop_ready_o && pop_valid_i;
  assign out_free    = !out_vld_q || out_o.ready;

  assign found = (state_q == S_SCAN) && rd_vld_q && map_vld_q[rd_addr_q] &&
                 (rd_data_q == cmd_q.param);
  assign scan_done = (state_q == S_SCAN) && !found && !rd_vld_q &&
                     (cnt_q == SW'(mccl_pkg::CcCount));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pop_data_i.cc;
    wr_en   = 1'b0;
    wr_addr = pop_data_i.cc;
    wr_data = learn_q;
    if (take) begin
      if (pop_data_i.op == mccl_pkg::OP_LOOKUP) begin
        rd_en = 1'b1;
      end else if (pop_data_i.op == mccl_pkg::OP_CC) begin
        rd_en = !learn_vld_q;
        wr_en = learn_vld_q;
      end
    end else if (state_q == S_SCAN) begin
      rd_en   = !found && (cnt_q < SW'(mccl_pkg::CcCount));
      rd_addr = cnt_q[CW-1:0];
    end else if (state_q == S_APPLY) begin
      wr_en   = cmd_q.op == mccl_pkg::OP_CONNECT;
      wr_addr = cmd_q.cc;
      wr_data = cmd_q.param;
    end
  end

  assign cc_param = use_learn_q ? learn_q : rd_data_q;

  always_comb begin
    res_fwd = cmd_q.fwd && (cmd_q.op == mccl_pkg::OP_MSG || cmd_q.op == mccl_pkg::OP_CC);
    res_wr  = (cmd_q.op == mccl_pkg::OP_CC) && map_vld_q[cmd_q.cc] &&
              ({1'b0, cc_param} < cfg_i.param_count);
    res_idx = res_wr ? cc_param : '0;
    res_val = res_wr ? cmd_q.value : '0;
    if (cmd_q.op == mccl_pkg::OP_LOOKUP && map_vld_q[cmd_q.cc]) begin
      res_map = $signed({1'b0, rd_data_q});
    end else begin
      res_map = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      map_vld_q   <= '0;
      learn_vld_q <= 1'b0;
      use_learn_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (state_q == S_RESOLVE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          rd_vld_q <= 1'b0;
          if (take) begin
            case (pop_data_i.op)
              mccl_pkg::OP_CC: begin
                state_q     <= S_RESOLVE;
                learn_vld_q <= 1'b0;
                use_learn_q <= learn_vld_q;
                if (learn_vld_q) begin
                  map_vld_q[pop_data_i.cc] <= 1'b1;
                end
              end
              mccl_pkg::OP_REMOVE: begin
                state_q                  <= S_RESOLVE;
                map_vld_q[pop_data_i.cc] <= 1'b0;
              end
              mccl_pkg::OP_DISARM: begin
                state_q     <= S_RESOLVE;
                learn_vld_q <= 1'b0;
              end
              mccl_pkg::OP_CONNECT, mccl_pkg::OP_ARM: begin
                cnt_q   <= '0;
                state_q <= S_SCAN;
              end
              default: begin
                state_q <= S_RESOLVE;
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_vld_q <= rd_en;
          if (rd_en) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (found) begin
            map_vld_q[rd_addr_q] <= 1'b0;
            state_q              <= S_APPLY;
          end else if (scan_done) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (cmd_q.op == mccl_pkg::OP_CONNECT) begin
            map_vld_q[cmd_q.cc] <= 1'b1;
          end
          if (cmd_q.op == mccl_pkg::OP_ARM) begin
            learn_vld_q <= 1'b1;
          end
          state_q <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= pop_data_i;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (state_q == S_APPLY && cmd_q.op == mccl_pkg::OP_ARM) begin
      learn_q <= cmd_q.param;
    end
    if (state_q == S_RESOLVE && out_free) begin
      out_fwd_q <= res_fwd;
      out_wr_q  <= res_wr;
      out_idx_q <= res_idx;
      out_val_q <= res_val;
      out_map_q <= res_map;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.forward      = out_fwd_q;
  assign out_o.param_write  = out_wr_q;
  assign out_o.write_index  = out_idx_q;
  assign out_o.write_value  = out_val_q;
  assign out_o.mapped_param = out_map_q;

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cnt_q <= SW'(mccl_pkg::CcCount))
    else $error("map scan counter ran past the last controller");

  a_learn_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(learn_vld_q) |-> $past(state_q == S_APPLY && cmd_q.op == mccl_pkg::OP_ARM))
    else $error("learn slot armed without an arm command");

  a_learn_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESOLVE && cmd_q.op == mccl_pkg::OP_CC |-> !learn_vld_q)
    else $error("learn slot still armed after a controller message");

endmodule

// ----- rtl/core/midi_cc_learn_mapper.sv -----
// ----------------------------------------------------------------------------
// MIDI controller learn mapper
// Filters MIDI messages, turns mapped control changes into parameter writes
// and edits the controller-to-parameter map on mapping commands.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake        Word
//   in_i      sink       valid/ready      func, status, data bytes, cc, param
//   out_o     source     valid/ready      forward, parameter write, look up
//   cfg       input      cfg_we_i only    register index and data
//
// Messages, look ups and removes go from idle straight to resolve; reads use
// the single registered read port of the controller map.
// Connect and in-range arm learn scan the map one entry a cycle.
// Reset empties the map and the learn slot at once; no clearing pass is needed.
// A two-word queue and the output register let input and output stall apart.
// ----------------------------------------------------------------------------
module midi_cc_learn_mapper (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mccl_in_if.sink                          in_i,
  mccl_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [mccl_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mccl_pkg::CfgDataW-1:0]    cfg_data_i
);

  mccl_pkg::cfg_t cfg_q;
  logic           push_valid;
  logic           push_ready;
  mccl_pkg::cmd_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  mccl_pkg::cmd_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mccl_pkg::CfgMidiChannel: begin
          cfg_q.midi_channel <= cfg_data_i[mccl_pkg::ChanW-1:0];
        end
        mccl_pkg::CfgCcIntercept: begin
          cfg_q.cc_intercept <= cfg_data_i[0];
        end
        mccl_pkg::CfgParamCount: begin
          cfg_q.param_count <= cfg_data_i[mccl_pkg::CountW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  mccl_front u_front (
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mccl_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mccl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

// ----- sim/tb_midi_cc_learn_mapper.sv -----
// ----------------------------------------------------------------------------
// Testbench for the MIDI controller learn mapper
// Drives messages and mapping commands through the input channel under
// several filter, intercept and parameter count settings, tracks the
// controller map and learn slot on its own, and compares every result word
// field by field in order of arrival. Both channels idle and stall at random,
// and one long output stall forces the input to back up.
// ----------------------------------------------------------------------------
module tb_midi_cc_learn_mapper;
  import mccl_pkg::*;

  localparam int unsigned MaxParams   = 4096;
  localparam int unsigned PhaseWords  = 104;
  localparam int unsigned HoldAt      = 200;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles  = 150;
  localparam int unsigned ReportMax   = 10;

  localparam logic [3:0] NibbleNoteOn = 4'h9;
  localparam logic [FuncW-1:0] FuncTop = '1;
  localparam logic signed [MapW-1:0] Unmapped = '1;

  localparam int unsigned PhaseChan  [5] = '{0, 1, 16, 31, 9};
  localparam int unsigned PhaseIcpt  [5] = '{0, 1, 0, 1, 0};
  localparam int unsigned PhaseCount [5] = '{4096, 16, 1, 8191, 100};

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [StatusW-1:0] status_byte;
    logic [DataW-1:0]   data_first;
    logic [DataW-1:0]   data_second;
    logic [CcW-1:0]     cc_index;
    logic [ParamW-1:0]  param_index;
  } mapper_word_t;

  typedef struct packed {
    logic              forward;
    logic              param_write;
    logic [ParamW-1:0] write_index;
    logic [DataW-1:0]  write_value;
    logic [MapW-1:0]   mapped_param;
  } mapper_result_t;

  class cc_map_tracker;
    logic signed [MapW-1:0] cc_map [CcCount];
    logic signed [MapW-1:0] learn_param;
    logic [ChanW-1:0]       midi_channel;
    logic                   cc_intercept;
    logic [CountW-1:0]      param_count;
    mapper_result_t         mapper_outcomes [$];
    int unsigned            failures;
    int unsigned            mismatches;

    function new();
      foreach (cc_map[i]) cc_map[i] = Unmapped;
      learn_param  = Unmapped;
      midi_channel = '0;
      cc_intercept = 1'b0;
      param_count  = '0;
      failures     = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgMidiChannel: midi_channel = data[ChanW-1:0];
        CfgCcIntercept: cc_intercept = data[0];
        CfgParamCount:  param_count  = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function void drop_first_binding(logic [ParamW-1:0] param);
      bit found;
      found = 1'b0;
      for (int i = 0; i < CcCount; i++) begin
        if (!found && cc_map[i] == {1'b0, param}) begin
          cc_map[i] = Unmapped;
          found = 1'b1;
        end
      end
    endfunction

    function mapper_result_t predict_mapping(mapper_word_t w);
      mapper_result_t         r;
      logic [CountW-1:0]      limit;
      logic [ChanW-1:0]       filter;
      logic [ChanW-1:0]       chan;
      logic signed [MapW-1:0] bound;
      r = '0;
      r.mapped_param = Unmapped;
      limit = (param_count > MaxParams) ? CountW'(MaxParams) : param_count;
      case (w.func)
        FuncMsg: begin
          filter = (midi_channel >= 1 && midi_channel <= ChanLast) ? midi_channel : '0;
          chan = (w.status_byte[7:4] == NibbleSystem) ? '0 :
                 ChanW'(w.status_byte[3:0]) + ChanW'(1);
          if (filter == '0 || chan == filter) begin
            r.forward = 1'b1;
            if (w.status_byte[7:4] == NibbleCc) begin
              if (!learn_param[MapW-1]) cc_map[w.data_first] = learn_param;
              learn_param = Unmapped;
              bound = cc_map[w.data_first];
              if (!bound[MapW-1] && bound[ParamW-1:0] < limit) begin
                r.param_write = 1'b1;
                r.write_index = bound[ParamW-1:0];
                r.write_value = w.data_second;
              end
              if (cc_intercept) r.forward = 1'b0;
            end
          end
        end
        FuncConnect: begin
          if (w.param_index < limit) begin
            drop_first_binding(w.param_index);
            cc_map[w.cc_index] = {1'b0, w.param_index};
          end
        end
        FuncRemove: cc_map[w.cc_index] = Unmapped;
        FuncArm: begin
          if (w.param_index < limit) begin
            drop_first_binding(w.param_index);
            learn_param = {1'b0, w.param_index};
          end else begin
            learn_param = Unmapped;
          end
        end
        FuncLookup: r.mapped_param = cc_map[w.cc_index];
        default: ;
      endcase
      return r;
    endfunction

    function void note_word(mapper_word_t w);
      mapper_outcomes.push_back(predict_mapping(w));
    endfunction

    function void check_word(mapper_result_t got);
      mapper_result_t exp;
      if (mapper_outcomes.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result word: fwd=%0b wr=%0b idx=%0d val=%0d map=%0d",
                   got.forward, got.param_write, got.write_index, got.write_value,
                   $signed(got.mapped_param));
        return;
      end
      exp = mapper_outcomes.pop_front();
      if (got !== exp) begin
        failures++;
        mismatches++;
        if (mismatches <= ReportMax)
          $display({"mismatch: exp fwd=%0b wr=%0b idx=%0d val=%0d map=%0d, ",
                    "got fwd=%0b wr=%0b idx=%0d val=%0d map=%0d"},
                   exp.forward, exp.param_write, exp.write_index, exp.write_value,
                   $signed(exp.mapped_param), got.forward, got.param_write,
                   got.write_index, got.write_value, $signed(got.mapped_param));
      end
    endfunction

    function int unsigned pending();
      return mapper_outcomes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  mccl_in_if  in_ch ();
  mccl_out_if out_ch ();

  cc_map_tracker tracker;
  int unsigned   words_in;
  int unsigned   burst_left;
  int unsigned   cur_channel;
  int unsigned   cur_count;

  midi_cc_learn_mapper dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic mapper_word_t pack_word(logic [FuncW-1:0] func, logic [StatusW-1:0] st,
                                             logic [DataW-1:0] d1, logic [DataW-1:0] d2,
                                             logic [CcW-1:0] cc, logic [ParamW-1:0] pi);
    mapper_word_t w;
    w.func        = func;
    w.status_byte = st;
    w.data_first  = d1;
    w.data_second = d2;
    w.cc_index    = cc;
    w.param_index = pi;
    return w;
  endfunction

  function automatic mapper_word_t random_word();
    return pack_word(FuncW'($urandom_range(FuncMsg, FuncLookup)), StatusW'($urandom()),
                     DataW'($urandom()), DataW'($urandom()), CcW'($urandom()),
                     ParamW'($urandom()));
  endfunction

  function automatic logic [ParamW-1:0] pick_param();
    int unsigned eff;
    int unsigned r;
    eff = (cur_count > MaxParams) ? MaxParams : cur_count;
    r = $urandom_range(0, 9);
    if (eff == 0 || r == 0) return ParamW'($urandom());
    if (r == 1 && eff < MaxParams) return ParamW'(eff);
    if (r < 7) return ParamW'($urandom_range(0, ((eff < 12) ? eff : 12) - 1));
    return ParamW'($urandom_range(0, eff - 1));
  endfunction

  function automatic logic [CcW-1:0] pick_cc();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return CcW'($urandom_range(0, 7));
    if (r < 17) return CcW'($urandom_range(120, 127));
    return CcW'($urandom());
  endfunction

  function automatic logic [3:0] pick_chan_nibble();
    if (cur_channel >= 1 && cur_channel <= ChanLast && $urandom_range(0, 4) != 0)
      return 4'(cur_channel - 1);
    return 4'($urandom());
  endfunction

  function automatic mapper_word_t rand_item();
    mapper_word_t w;
    int unsigned  r;
    w = random_word();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      w.func        = FuncMsg;
      w.status_byte = {NibbleCc, pick_chan_nibble()};
      w.data_first  = pick_cc();
    end else if (r < 42) begin
      w.func        = FuncConnect;
      w.cc_index    = pick_cc();
      w.param_index = pick_param();
    end else if (r < 50) begin
      w.func     = FuncRemove;
      w.cc_index = pick_cc();
    end else if (r < 56) begin
      w.func        = FuncArm;
      w.param_index = pick_param();
    end else if (r < 72) begin
      w.func     = FuncLookup;
      w.cc_index = pick_cc();
    end else if (r < 88) begin
      w.func             = FuncMsg;
      w.status_byte[3:0] = pick_chan_nibble();
    end
    return w;
  endfunction

  task automatic send_word(input mapper_word_t w);
    int unsigned gap;
    int unsigned r;
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      gap = (r < 4) ? 0 : (r < 9) ? $urandom_range(1, 6) : $urandom_range(10, 30);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.func        <= w.func;
    in_ch.status_byte <= w.status_byte;
    in_ch.data_first  <= w.data_first;
    in_ch.data_second <= w.data_second;
    in_ch.cc_index    <= w.cc_index;
    in_ch.param_index <= w.param_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_word(w);
    words_in++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic apply_config(input int unsigned chan, input int unsigned icpt,
                              input int unsigned count);
    logic [CfgIdxW-1:0]  idx [3];
    logic [CfgDataW-1:0] val [3];
    idx = '{CfgMidiChannel, CfgCcIntercept, CfgParamCount};
    val = '{CfgDataW'(chan), CfgDataW'(icpt), CfgDataW'(count)};
    for (int i = 0; i < 3; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
      tracker.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_channel = chan;
    cur_count   = count;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : collect
    mapper_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.forward      = out_ch.forward;
      got.param_write  = out_ch.param_write;
      got.write_index  = out_ch.write_index;
      got.write_value  = out_ch.write_value;
      got.mapped_param = out_ch.mapped_param;
      tracker.check_word(got);
    end
  end

  initial begin : sink_side
    int unsigned cyc;
    int unsigned mode;
    int unsigned hold;
    bit          hold_done;
    cyc = 0;
    mode = 0;
    hold = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 80 == 0) mode = $urandom_range(0, 3);
      if (!hold_done && words_in >= HoldAt) begin
        hold = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (cyc % 3 == 0);
          default: out_ch.ready <= ($urandom_range(0, 15) > 1);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_midi_cc_learn_mapper NOT OK");
    $finish;
  end

  initial begin : stimulus
    mapper_word_t w;
    int unsigned  target;
    int unsigned  n;
    logic [CcW-1:0] c;
    logic [3:0]     nib;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = '0;
    in_ch.status_byte = '0;
    in_ch.data_first  = '0;
    in_ch.data_second = '0;
    in_ch.cc_index    = '0;
    in_ch.param_index = '0;
    words_in    = 0;
    burst_left  = 0;
    cur_channel = 0;
    cur_count   = 0;
    tracker = new();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apply_config(0, 0, MaxParams);
    send_word(pack_word(FuncLookup, 8'h00, 7'd0, 7'd0, 7'd0, 12'd0));
    send_word(pack_word(FuncConnect, 8'h00, 7'd0, 7'd0, 7'd127, 12'd4095));
    send_word(pack_word(FuncLookup, 8'hFF, 7'd127, 7'd127, 7'd127, 12'd4095));
    send_word(pack_word(FuncMsg, {NibbleCc, 4'h0}, 7'd127, 7'd127, 7'd0, 12'd0));
    send_word(pack_word(FuncConnect, 8'h00, 7'd0, 7'd0, 7'd0, 12'd4095));
    send_word(pack_word(FuncLookup, 8'h00, 7'd0, 7'd0, 7'd127, 12'd0));
    send_word(pack_word(FuncArm, 8'h00, 7'd0, 7'd0, 7'd0, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleNoteOn, 4'h0}, 7'd5, 7'd100, 7'd0, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleCc, 4'hF}, 7'd5, 7'd0, 7'd0, 12'd0));
    send_word(pack_word(FuncLookup, 8'h00, 7'd0, 7'd0, 7'd5, 12'd0));
    send_word(pack_word(FuncRemove, 8'h00, 7'd0, 7'd0, 7'd5, 12'd0));
    send_word(pack_word(FuncLookup, 8'h00, 7'd0, 7'd0, 7'd5, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleSystem, 4'hF}, 7'd0, 7'd0, 7'd0, 12'd0));
    send_word(pack_word(FuncMsg, 8'h00, 7'd127, 7'd127, 7'd127, 12'd4095));
    send_word(pack_word(FuncArm, 8'h00, 7'd0, 7'd0, 7'd0, 12'd4095));
    send_word(pack_word(FuncLookup, 8'h00, 7'd0, 7'd0, 7'd0, 12'd0));
    for (int f = FuncLookup + 1; f <= FuncTop; f++) begin
      w = random_word();
      w.func = FuncW'(f);
      send_word(w);
    end
    send_word(pack_word(FuncMsg, {NibbleCc, 4'h3}, 7'd0, 7'd64, 7'd0, 12'd0));
    settle();

    apply_config(ChanLast, 1, 8191);
    send_word(pack_word(FuncMsg, {NibbleCc, 4'hF}, 7'd0, 7'd1, 7'd0, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleCc, 4'h0}, 7'd0, 7'd2, 7'd0, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleSystem, 4'h8}, 7'd0, 7'd0, 7'd0, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleNoteOn, 4'hF}, 7'd60, 7'd90, 7'd0, 12'd0));
    send_word(pack_word(FuncArm, 8'h00, 7'd0, 7'd0, 7'd0, 12'd7));
    settle();

    apply_config(31, 0, 0);
    send_word(pack_word(FuncArm, 8'h00, 7'd0, 7'd0, 7'd0, 12'd0));
    send_word(pack_word(FuncConnect, 8'h00, 7'd0, 7'd0, 7'd1, 12'd0));
    send_word(pack_word(FuncLookup, 8'h00, 7'd0, 7'd0, 7'd1, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleCc, 4'h0}, 7'd0, 7'd9, 7'd0, 12'd0));
    send_word(pack_word(FuncMsg, {NibbleCc, 4'h5}, 7'd3, 7'd9, 7'd0, 12'd0));
    send_word(pack_word(FuncLookup, 8'h00, 7'd0, 7'd0, 7'd3, 12'd0));
    settle();

    for (int p = 0; p < 5; p++) begin
      apply_config(PhaseChan[p], PhaseIcpt[p], PhaseCount[p]);
      target = words_in + PhaseWords;
      while (words_in < target) begin
        if ($urandom_range(0, 3) == 0) begin
          // A learn runs as arm, optional noise, control changes on one
          // controller, then a look up of that controller.
          c = pick_cc();
          nib = pick_chan_nibble();
          w = random_word();
          w.func = FuncArm;
          w.param_index = pick_param();
          send_word(w);
          if ($urandom_range(0, 4) == 0) begin
            w = random_word();
            w.func = FuncMsg;
            w.status_byte[7:4] = NibbleNoteOn;
            send_word(w);
          end
          n = $urandom_range(1, 4);
          repeat (n) begin
            w = random_word();
            w.func = FuncMsg;
            w.status_byte = {NibbleCc, nib};
            w.data_first = c;
            send_word(w);
          end
          w = random_word();
          w.func = FuncLookup;
          w.cc_index = c;
          send_word(w);
        end else begin
          send_word(rand_item());
        end
      end
      settle();
    end

    repeat (TailCycles) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("tb_midi_cc_learn_mapper OK");
    end else begin
      $display("tb_midi_cc_learn_mapper NOT OK");
    end
    $finish;
  end

endmodule
